// ----- rtl/core/bcst_pkg.sv -----
// Package for the beat clock sync tracker: request and result payload types,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package bcst_pkg;

  localparam int GAIN_W  = 17;
  localparam int MINS_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [GAIN_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_REPEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_FIRST_RST  = 17'd6554;
  localparam logic [GAIN_W-1:0] GAIN_REPEAT_RST = 17'd1966;
  localparam logic [MINS_W-1:0] MIN_SAMPLES_RST = 8'd4;

  localparam logic CMD_CTRL = 1'b0;
  localparam logic CMD_BEAT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] remote_time;
    logic [31:0] local_time;
    logic [15:0] beat_number;
    logic [31:0] play_at_master;
    logic [15:0] tempo_code;
    logic [7:0]  velocity_in;
    logic [7:0]  play_state_in;
  } bcst_in_t;

  typedef struct packed {
    logic signed [31:0] clock_offset;
    logic [15:0] sample_count;
    logic        converged;
    logic        beat_repeat;
    logic [15:0] pending_beat;
    logic [31:0] pending_play_time;
    logic [31:0] pending_enqueue_time;
    logic [15:0] tempo_eighths;
    logic [7:0]  velocity_out;
    logic [7:0]  play_state_out;
    logic [31:0] last_ctrl_time;
    logic [31:0] last_beat_time;
  } bcst_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/bcst_if.sv -----
// Valid/ready channel interfaces for requests and results of the tracker.
// Depends on bcst_pkg for the payload types.
`default_nettype none

interface bcst_in_if
  import bcst_pkg::*;
();
  logic     valid;
  logic     ready;
  bcst_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bcst_out_if
  import bcst_pkg::*;
();
  logic      valid;
  logic      ready;
  bcst_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/beat_clock_sync_tracker_top.sv -----
// Beat clock sync tracker top level: offset EMA, sample count, beat and
// control latches. Depends on bcst_pkg and the channel interfaces in bcst_if.
`default_nettype none

// Usage
// -----
// msg carries one request per control or beat message (cmd 0 or 1). res
// carries one result per request: the tracker state right after that
// request has been applied. Both are valid/ready; a transfer happens on a
// rising clk edge with valid and ready high.
// A request goes into an input register; from there its offset sample is
// blended into the estimate (one 33x18 signed multiply, an add and a round
// toward zero) and the updated state lands in the result register.
// Throughput is one request per cycle while res does not stall, set by the
// single multiply in the estimate update loop.
// When res stalls, the result register holds and one more request is still
// taken into the input register; msg.ready then drops until res drains.
// The cfg port writes gain_first, gain_repeat and min_samples (indexes 0, 1,
// 2; other indexes are ignored). Write it only while the block is idle.
// rst (synchronous, active high) clears all tracker state, empties both
// registers and restores the register reset values.
module beat_clock_sync_tracker_top
  import bcst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  bcst_in_if.sink                    msg,
  bcst_out_if.source                 res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [GAIN_W-1:0] gain_first;
  logic [GAIN_W-1:0] gain_repeat;
  logic [MINS_W-1:0] min_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_first  <= GAIN_FIRST_RST;
      gain_repeat <= GAIN_REPEAT_RST;
      min_samples <= MIN_SAMPLES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_FIRST:  gain_first  <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_REPEAT: gain_repeat <= cfg_data[GAIN_W-1:0];
        CFG_MIN_SAMPLES: min_samples <= cfg_data[MINS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic     stg_valid;
  bcst_in_t stg;
  logic     out_valid;
  logic     advance;
  logic     fire;

  // the result register frees up when it is empty or being taken
  assign advance   = !out_valid || res.ready;
  assign fire      = stg_valid && advance;
  assign msg.ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      stg <= msg.data;
    end
  end

  // tracker state
  logic signed [31:0] offset_est;
  logic [15:0]        sample_cnt;
  logic               conv_flag;
  logic               seen_beat;
  logic [15:0]        prev_beat;
  logic [15:0]        pend_beat;
  logic [31:0]        pend_play;
  logic [31:0]        pend_enq;
  logic [15:0]        tempo;
  logic [7:0]         velocity;
  logic [7:0]         play_state;
  logic [31:0]        ctrl_time;
  logic [31:0]        beat_time;

  logic signed [31:0] offset_est_next;
  logic [15:0]        sample_cnt_next;
  logic               conv_flag_next;
  logic               seen_beat_next;
  logic [15:0]        prev_beat_next;
  logic [15:0]        pend_beat_next;
  logic [31:0]        pend_play_next;
  logic [31:0]        pend_enq_next;
  logic [15:0]        tempo_next;
  logic [7:0]         velocity_next;
  logic [7:0]         play_state_next;
  logic [31:0]        ctrl_time_next;
  logic [31:0]        beat_time_next;

  // estimate update datapath
  logic               is_repeat;
  logic [GAIN_W-1:0]  gain_raw;
  logic [GAIN_W-1:0]  gain;
  logic signed [31:0] sample;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [35:0] blend;
  logic signed [35:0] blend_rnd;

  always_comb begin
    is_repeat = (stg.cmd == CMD_BEAT) && seen_beat && (stg.beat_number == prev_beat);
    gain_raw  = is_repeat ? gain_repeat : gain_first;
    // clamp gains above one to exactly one
    gain      = (gain_raw > Q16_ONE) ? Q16_ONE : gain_raw;
    sample    = stg.remote_time - stg.local_time;
    diff      = {sample[31], sample} - {offset_est[31], offset_est};
    prod      = diff * $signed({1'b0, gain});
    // prev + floor(prod / 2^16), then bump toward zero if negative and inexact
    blend     = {{4{offset_est[31]}}, offset_est} + {{1{prod[50]}}, prod[50:16]};
    blend_rnd = blend + {35'd0, (blend[35] && (prod[15:0] != 16'd0))};

    offset_est_next = (sample_cnt == 16'd0) ? sample : blend_rnd[31:0];
    sample_cnt_next = (sample_cnt == COUNT_MAX) ? sample_cnt : sample_cnt + 16'd1;
    conv_flag_next  = conv_flag || (sample_cnt_next >= {8'd0, min_samples});

    seen_beat_next  = seen_beat;
    prev_beat_next  = prev_beat;
    pend_beat_next  = pend_beat;
    pend_play_next  = pend_play;
    pend_enq_next   = pend_enq;
    tempo_next      = tempo;
    velocity_next   = velocity;
    play_state_next = play_state;
    ctrl_time_next  = ctrl_time;
    beat_time_next  = beat_time;

    if (stg.cmd == CMD_CTRL) begin
      tempo_next      = stg.tempo_code;
      velocity_next   = stg.velocity_in;
      play_state_next = stg.play_state_in;
      ctrl_time_next  = stg.local_time;
    end else begin
      // latch a new beat; a repeat only refreshes the arrival time
      if (!is_repeat) begin
        pend_beat_next = stg.beat_number;
        pend_play_next = stg.play_at_master;
        pend_enq_next  = stg.local_time;
        prev_beat_next = stg.beat_number;
        seen_beat_next = 1'b1;
      end
      beat_time_next = stg.local_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_est <= '0;
      sample_cnt <= '0;
      conv_flag  <= 1'b0;
      seen_beat  <= 1'b0;
      prev_beat  <= '0;
      pend_beat  <= '0;
      pend_play  <= '0;
      pend_enq   <= '0;
      tempo      <= '0;
      velocity   <= '0;
      play_state <= '0;
      ctrl_time  <= '0;
      beat_time  <= '0;
    end else if (fire) begin
      offset_est <= offset_est_next;
      sample_cnt <= sample_cnt_next;
      conv_flag  <= conv_flag_next;
      seen_beat  <= seen_beat_next;
      prev_beat  <= prev_beat_next;
      pend_beat  <= pend_beat_next;
      pend_play  <= pend_play_next;
      pend_enq   <= pend_enq_next;
      tempo      <= tempo_next;
      velocity   <= velocity_next;
      play_state <= play_state_next;
      ctrl_time  <= ctrl_time_next;
      beat_time  <= beat_time_next;
    end
  end

  // result register
  bcst_out_t res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data.clock_offset         <= offset_est_next;
      res_data.sample_count         <= sample_cnt_next;
      res_data.converged            <= conv_flag_next;
      res_data.beat_repeat          <= is_repeat;
      res_data.pending_beat         <= pend_beat_next;
      res_data.pending_play_time    <= pend_play_next;
      res_data.pending_enqueue_time <= pend_enq_next;
      res_data.tempo_eighths        <= tempo_next;
      res_data.velocity_out         <= velocity_next;
      res_data.play_state_out       <= play_state_next;
      res_data.last_ctrl_time       <= ctrl_time_next;
      res_data.last_beat_time       <= beat_time_next;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = res_data;

endmodule

`default_nettype wire
